// File: design/dafe_pkg.sv
// ----------------------------------------------------------------------------
// dafe_pkg
// Shared types and constants of the assembly flowshop schedule evaluator.
// ----------------------------------------------------------------------------
package dafe_pkg;

  localparam int MACHINES_DEF   = 8;
  localparam int FACTORIES_DEF  = 4;
  localparam int TIME_WIDTH_DEF = 24;

  localparam int PROC_W    = 8;
  localparam int PROC_N    = 8;
  localparam int MODE_W    = 2;
  localparam int CHOSEN_W  = 2;
  localparam int OUT_T_W   = 24;
  localparam int SUM_W     = 32;
  localparam int MU_W      = 4;
  localparam int FU_W      = 3;
  localparam int CFG_DW    = 4;
  localparam int CFG_IW    = 1;
  localparam int IN_DW     = 80;
  localparam int OUT_DW    = 88;

  localparam logic [MU_W-1:0] MU_RESET = 4'd8;
  localparam logic [FU_W-1:0] FU_RESET = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_JOB    = 2'd0,
    MODE_ASM    = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_MACHINES  = 1'd0,
    REG_FACTORIES = 1'd1
  } reg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHAIN  = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_COMMIT = 7'b0001000,
    ST_ASM    = 7'b0010000,
    ST_CLR    = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic compute;
    logic commit;
    logic clear;
    logic act;
  } cell_ctrl_t;

endpackage

// File: design/distributed_assembly_flowshop_eval_unit.sv
// ----------------------------------------------------------------------------
// distributed_assembly_flowshop_eval_unit
// Schedule evaluator: a row of machine cells, factory scan, assembly stage.
// ----------------------------------------------------------------------------
// One request is handled at a time. A job request runs a wavefront through
// the row of MACHINES cells, one cell per cycle with all factories in
// parallel, then scans the active factories one per cycle for the earliest
// finish, then commits. The result register lets a new request be accepted
// while the previous result still waits. Reset restores the default
// register settings and clears control, schedule and result state; the
// request copies, chain registers and output data are not reset.
module distributed_assembly_flowshop_eval_unit import dafe_pkg::*; #(
  parameter int MACHINES   = MACHINES_DEF,
  parameter int FACTORIES  = FACTORIES_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  // mode, proc_time_m0..proc_time_m7, assembly_time
  input  logic [IN_DW-1:0]    in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // chosen_factory, job_completion, set_completion, total_flowtime, saturated
  output logic [OUT_DW-1:0]   out_tdata
);

  localparam int FW = (FACTORIES > 1) ? $clog2(FACTORIES) : 1;
  localparam int SW = (MACHINES > 1) ? $clog2(MACHINES) : 1;
  localparam int TW = TIME_WIDTH;

  state_t                      state_r;
  logic [SW-1:0]               step_r;
  logic [FW-1:0]               scan_r;
  logic [FW-1:0]               sel_r;
  logic [TW-1:0]               best_r;
  logic [MU_W-1:0]             mu_r;
  logic [FU_W-1:0]             fu_r;
  logic [MU_W-1:0]             mu_c;
  logic [4:0]                  fu_c;
  logic [PROC_N-1:0][PROC_W-1:0] proc_r;
  logic [PROC_W-1:0]           asm_r;
  logic [TW-1:0]               release_r;
  logic [TW-1:0]               asm_free_r;
  logic [SUM_W-1:0]            sum_r;
  logic                        sat_r;
  logic [CHOSEN_W-1:0]         res_chosen_r;
  logic [TW-1:0]               res_job_r;
  logic [TW-1:0]               res_set_r;
  logic                        out_valid_r;
  logic [OUT_DW-1:0]           out_data_r;

  logic [FACTORIES-1:0][TW-1:0] chain_w [MACHINES];
  logic [FACTORIES-1:0][TW-1:0] prev_w  [MACHINES];
  logic [MACHINES-1:0]          sat_w;
  cell_ctrl_t                   ctrl_w  [MACHINES];

  logic                         in_acc;
  logic                         out_free;
  logic [TW-1:0]                cand;
  logic [TW-1:0]                asm_start;
  logic [TW:0]                  asm_sum;
  logic [TW-1:0]                set_c;
  logic                         set_sat;
  logic [SUM_W:0]               flow_sum;
  logic [TW+OUT_T_W-1:0]        job_ext;
  logic [TW+OUT_T_W-1:0]        set_ext;

  always_comb begin
    if (mu_r == '0) begin
      mu_c = MU_W'(1);
    end else if (mu_r > MU_W'(MACHINES)) begin
      mu_c = MU_W'(MACHINES);
    end else begin
      mu_c = mu_r;
    end
    if (fu_r == '0) begin
      fu_c = 5'd1;
    end else if (5'(fu_r) > 5'(FACTORIES)) begin
      fu_c = 5'(FACTORIES);
    end else begin
      fu_c = 5'(fu_r);
    end
  end

  for (genvar i = 0; i < MACHINES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_w[i] = '0;
    end else begin : g_rest
      assign prev_w[i] = chain_w[i-1];
    end
    assign ctrl_w[i].compute = (state_r == ST_CHAIN) && (step_r == SW'(i));
    assign ctrl_w[i].commit  = (state_r == ST_COMMIT);
    assign ctrl_w[i].clear   = (state_r == ST_CLR);
    assign ctrl_w[i].act     = (MU_W'(i) < mu_c);

    dafe_cell #(
      .FACTORIES  (FACTORIES),
      .TIME_WIDTH (TW),
      .FW         (FW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl_w[i]),
      .fu_c      (fu_c),
      .sel       (sel_r),
      .proc      (proc_r[i]),
      .prev_in   (prev_w[i]),
      .chain_out (chain_w[i]),
      .sat       (sat_w[i])
    );
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cand      = chain_w[MACHINES-1][scan_r];

  assign asm_start = (asm_free_r > release_r) ? asm_free_r : release_r;
  assign asm_sum   = {1'b0, asm_start} + {{(TW+1-PROC_W){1'b0}}, asm_r};
  assign set_sat   = asm_sum[TW];
  assign set_c     = set_sat ? '1 : asm_sum[TW-1:0];
  assign flow_sum  = {1'b0, sum_r} + (SUM_W+1)'(set_c);

  assign job_ext = {{OUT_T_W{1'b0}}, res_job_r};
  assign set_ext = {{OUT_T_W{1'b0}}, res_set_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= MU_RESET;
      fu_r <= FU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MACHINES:  mu_r <= cfg_data[MU_W-1:0];
        REG_FACTORIES: fu_r <= cfg_data[FU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int m = 0; m < PROC_N; m++) begin
        proc_r[m] <= in_tdata[MODE_W + m*PROC_W +: PROC_W];
      end
      asm_r <= in_tdata[MODE_W + PROC_N*PROC_W +: PROC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      scan_r       <= '0;
      sel_r        <= '0;
      best_r       <= '0;
      release_r    <= '0;
      asm_free_r   <= '0;
      sum_r        <= '0;
      sat_r        <= 1'b0;
      res_chosen_r <= '0;
      res_job_r    <= '0;
      res_set_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (|sat_w) begin
        sat_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            res_chosen_r <= '0;
            res_job_r    <= '0;
            res_set_r    <= '0;
            step_r       <= '0;
            scan_r       <= '0;
            case (mode_t'(in_tdata[MODE_W-1:0]))
              MODE_JOB:   state_r <= ST_CHAIN;
              MODE_ASM:   state_r <= ST_ASM;
              MODE_CLEAR: state_r <= ST_CLR;
              default:    state_r <= ST_FIN;
            endcase
          end
        end
        ST_CHAIN: begin
          if (step_r == SW'(MACHINES - 1)) begin
            state_r <= ST_SCAN;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_SCAN: begin
          if (scan_r == '0 || cand < best_r) begin
            best_r <= cand;
            sel_r  <= scan_r;
          end
          if (5'(scan_r) == fu_c - 5'd1) begin
            state_r <= ST_COMMIT;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_COMMIT: begin
          if (best_r > release_r) begin
            release_r <= best_r;
          end
          res_chosen_r <= CHOSEN_W'(5'(sel_r));
          res_job_r    <= best_r;
          state_r      <= ST_FIN;
        end
        ST_ASM: begin
          res_set_r  <= set_c;
          asm_free_r <= set_c;
          release_r  <= '0;
          if (flow_sum[SUM_W]) begin
            sum_r <= '1;
          end else begin
            sum_r <= flow_sum[SUM_W-1:0];
          end
          if (set_sat || flow_sum[SUM_W]) begin
            sat_r <= 1'b1;
          end
          state_r <= ST_FIN;
        end
        ST_CLR: begin
          release_r  <= '0;
          asm_free_r <= '0;
          sum_r      <= '0;
          sat_r      <= 1'b0;
          state_r    <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_data_r <= {5'b0, sat_r, sum_r, set_ext[OUT_T_W-1:0], job_ext[OUT_T_W-1:0],
                     res_chosen_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request accepted while busy");

  a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) |-> (5'(sel_r) < fu_c))
    else $error("chosen factory beyond active factories");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sat_r && state_r != ST_CLR) |=> sat_r)
    else $error("saturation flag dropped without clear");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHAIN) |-> (32'(step_r) < MACHINES))
    else $error("wavefront step beyond cell row");

endmodule

// File: design/dafe_cell.sv
// ----------------------------------------------------------------------------
// dafe_cell
// One machine column: free times of this machine in every factory and the
// completion chain step max(prev, free) + p, computed for all factories.
// ----------------------------------------------------------------------------
module dafe_cell import dafe_pkg::*; #(
  parameter int FACTORIES  = FACTORIES_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FW         = (FACTORIES > 1) ? $clog2(FACTORIES) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cell_ctrl_t                             ctrl,
  input  logic [4:0]                             fu_c,
  input  logic [FW-1:0]                          sel,
  input  logic [PROC_W-1:0]                      proc,
  input  logic [FACTORIES-1:0][TIME_WIDTH-1:0]   prev_in,
  output logic [FACTORIES-1:0][TIME_WIDTH-1:0]   chain_out,
  output logic                                   sat
);

  logic [FACTORIES-1:0][TIME_WIDTH-1:0] free_r;
  logic [FACTORIES-1:0][TIME_WIDTH-1:0] chain_r;
  logic [FACTORIES-1:0][TIME_WIDTH-1:0] chain_nxt;
  logic [FACTORIES-1:0]                 sat_k;

  always_comb begin
    for (int k = 0; k < FACTORIES; k++) begin
      logic [TIME_WIDTH-1:0] start;
      logic [TIME_WIDTH:0]   s;
      start = (prev_in[k] > free_r[k]) ? prev_in[k] : free_r[k];
      s = {1'b0, start} + {{(TIME_WIDTH+1-PROC_W){1'b0}}, proc};
      if (!ctrl.act) begin
        chain_nxt[k] = prev_in[k];
        sat_k[k]     = 1'b0;
      end else if (s[TIME_WIDTH]) begin
        chain_nxt[k] = '1;
        sat_k[k]     = (5'(k) < fu_c);
      end else begin
        chain_nxt[k] = s[TIME_WIDTH-1:0];
        sat_k[k]     = 1'b0;
      end
    end
  end

  assign sat       = ctrl.compute & (|sat_k);
  assign chain_out = chain_r;

  always_ff @(posedge clk) begin
    if (ctrl.compute) begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      free_r <= '0;
    end else if (ctrl.commit && ctrl.act) begin
      for (int k = 0; k < FACTORIES; k++) begin
        if (FW'(k) == sel) begin
          free_r[k] <= chain_r[k];
        end
      end
    end
  end

endmodule

// File: bench/tb_distributed_assembly_flowshop_eval_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distributed_assembly_flowshop_eval_unit
// Self-checking bench for the assembly flowshop schedule evaluator.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first: extreme times, every mode,
// the register clamps, empty sets and clears. Random phases follow, each
// under its own register setting, built mostly from whole sets (jobs, then
// an assemble) with clears and unused-mode requests mixed in. A run of
// maximum assembly times near the end keeps the block busy back to back.
// Each result is checked against a behavioral scheduler kept inside the
// bench, but for the typed table rows, which carry their own values.
// ----------------------------------------------------------------------------
module tb_distributed_assembly_flowshop_eval_unit;
  import dafe_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int TW          = TIME_WIDTH_DEF;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASE_REQS  = 200;
  localparam int SOAK_REQS   = 30;
  localparam logic [63:0] ONES = {8{8'hFF}};

  typedef struct packed {
    logic [5:0]      pad;
    logic [7:0]      asm_time;
    logic [7:0][7:0] ptime;
    mode_t           mode;
  } request_t;

  typedef struct packed {
    logic [4:0]       pad;
    logic             sat;
    logic [SUM_W-1:0] total;
    logic [23:0]      set_c;
    logic [23:0]      job_c;
    logic [1:0]       chosen;
  } result_t;

  typedef enum logic [1:0] {ROW_TYPED, ROW_PRED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [3:0] cfg_mu;
    logic [3:0] cfg_fu;
    request_t   req;
    result_t    want;
  } dir_row_t;

  localparam request_t NO_REQ = '0;
  localparam result_t  NO_RES = '0;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  reg_idx_t          cfg_index  = REG_MACHINES;
  logic [CFG_DW-1:0] cfg_data   = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;

  // scheduler state and register copies
  logic [TW-1:0]     mach_free [FACTORIES_DEF][MACHINES_DEF];
  logic [TW-1:0]     set_release;
  logic [TW-1:0]     asm_free;
  logic [SUM_W-1:0]  flow_total;
  logic              sat_seen;
  logic [MU_W-1:0]   mu_reg = MU_RESET;
  logic [FU_W-1:0]   fu_reg = FU_RESET;

  result_t pending_results [$];
  int      mismatches = 0;
  int      burst_left = 0;
  int      hold_reqs  = 0;
  bit      idle_on    = 1'b1;
  bit      stall_on   = 1'b1;

  dir_row_t dir_rows [26] = '{
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, 64'd0, MODE_JOB}, NO_RES},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'hFF, ONES, MODE_UNUSED}, NO_RES},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, ONES, MODE_JOB},
      '{5'd0, 1'b0, 32'd0, 24'd0, 24'd2040, 2'd0}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, ONES, MODE_JOB},
      '{5'd0, 1'b0, 32'd0, 24'd0, 24'd2040, 2'd1}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, ONES, MODE_JOB},
      '{5'd0, 1'b0, 32'd0, 24'd0, 24'd2040, 2'd2}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, ONES, MODE_JOB},
      '{5'd0, 1'b0, 32'd0, 24'd0, 24'd2040, 2'd3}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, ONES, MODE_JOB},
      '{5'd0, 1'b0, 32'd0, 24'd0, 24'd2295, 2'd0}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd255, 64'd0, MODE_ASM},
      '{5'd0, 1'b0, 32'd2550, 24'd2550, 24'd0, 2'd0}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, ONES, MODE_ASM},
      '{5'd0, 1'b0, 32'd5100, 24'd2550, 24'd0, 2'd0}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'hFF, ONES, MODE_CLEAR}, NO_RES},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd255, 64'd0, MODE_ASM},
      '{5'd0, 1'b0, 32'd255, 24'd255, 24'd0, 2'd0}},
    '{ROW_CFG, 4'd1, 4'd1, NO_REQ, NO_RES},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFC8, MODE_JOB},
      '{5'd0, 1'b0, 32'd255, 24'd0, 24'd200, 2'd0}},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, 64'h0000_0000_0000_0037, MODE_JOB},
      '{5'd0, 1'b0, 32'd255, 24'd0, 24'd255, 2'd0}},
    '{ROW_CFG, 4'd0, 4'd0, NO_REQ, NO_RES},
    '{ROW_PRED, 4'd0, 4'd0, '{6'd0, 8'd0, 64'h1, MODE_JOB}, NO_RES},
    '{ROW_CFG, 4'd15, 4'd7, NO_REQ, NO_RES},
    '{ROW_PRED, 4'd0, 4'd0, '{6'd0, 8'd0, {8{8'hAA}}, MODE_JOB}, NO_RES},
    '{ROW_PRED, 4'd0, 4'd0, '{6'd0, 8'd0, {8{8'h55}}, MODE_JOB}, NO_RES},
    '{ROW_PRED, 4'd0, 4'd0, '{6'd0, 8'hAA, 64'd0, MODE_ASM}, NO_RES},
    '{ROW_CFG, 4'd9, 4'd5, NO_REQ, NO_RES},
    '{ROW_PRED, 4'd0, 4'd0, '{6'd0, 8'd0, 64'h0123_4567_89AB_CDEF, MODE_JOB}, NO_RES},
    '{ROW_PRED, 4'd0, 4'd0, '{6'd0, 8'h55, 64'd0, MODE_UNUSED}, NO_RES},
    '{ROW_PRED, 4'd0, 4'd0, '{6'd0, 8'h55, 64'd0, MODE_ASM}, NO_RES},
    '{ROW_CFG, 4'd8, 4'd4, NO_REQ, NO_RES},
    '{ROW_TYPED, 4'd0, 4'd0, '{6'd0, 8'd0, 64'd0, MODE_CLEAR}, NO_RES}
  };

  distributed_assembly_flowshop_eval_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_schedule();
    foreach (mach_free[k, m]) mach_free[k][m] = '0;
    set_release = '0;
    asm_free    = '0;
    flow_total  = '0;
    sat_seen    = 1'b0;
  endfunction

  function automatic logic [TW-1:0] sat_add(logic [TW-1:0] a, logic [7:0] b);
    logic [TW:0] s;
    s = a + b;
    if (s[TW]) begin
      sat_seen = 1'b1;
      return '1;
    end
    return s[TW-1:0];
  endfunction

  function automatic result_t evaluate_request(request_t r);
    result_t       res;
    logic [TW-1:0] chain [FACTORIES_DEF][MACHINES_DEF];
    logic [TW-1:0] prev, best, start;
    longint unsigned sum;
    int mu, fu, sel;
    res = '0;
    mu  = (mu_reg == 0) ? 1 : ((mu_reg > MACHINES_DEF) ? MACHINES_DEF : int'(mu_reg));
    fu  = (fu_reg == 0) ? 1 : ((fu_reg > FACTORIES_DEF) ? FACTORIES_DEF : int'(fu_reg));
    case (r.mode)
      MODE_JOB: begin
        best = '0;
        sel  = 0;
        for (int k = 0; k < fu; k++) begin
          prev = '0;
          for (int m = 0; m < mu; m++) begin
            start = mach_free[k][m];
            if (m != 0 && prev > start) start = prev;
            prev = sat_add(start, r.ptime[m]);
            chain[k][m] = prev;
          end
          if (k == 0 || prev < best) begin
            best = prev;
            sel  = k;
          end
        end
        for (int m = 0; m < mu; m++) mach_free[sel][m] = chain[sel][m];
        if (best > set_release) set_release = best;
        res.chosen = 2'(sel);
        res.job_c  = best;
      end
      MODE_ASM: begin
        start = (asm_free > set_release) ? asm_free : set_release;
        res.set_c   = sat_add(start, r.asm_time);
        asm_free    = res.set_c;
        set_release = '0;
        sum = longint'(flow_total) + longint'(res.set_c);
        if (sum > 64'hFFFF_FFFF) begin
          sat_seen = 1'b1;
          sum = 64'hFFFF_FFFF;
        end
        flow_total = sum[SUM_W-1:0];
      end
      MODE_CLEAR: clear_schedule();
      default: ;
    endcase
    res.total = flow_total;
    res.sat   = sat_seen;
    return res;
  endfunction

  function automatic logic [7:0] rand_time();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_request(request_t r, bit typed, result_t want);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
    want = typed ? want : evaluate_request(r);
    if (typed) void'(evaluate_request(r));
    pending_results = {pending_results, want};
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MACHINES) mu_reg = val;
    else fu_reg = val[FU_W-1:0];
  endtask

  task automatic set_config(logic [3:0] mu, logic [3:0] fu);
    wait_idle();
    write_reg(REG_MACHINES, mu);
    write_reg(REG_FACTORIES, fu);
  endtask

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %h with nothing pending at %0t", got, $realtime);
      return;
    end
    want = pending_results.pop_front();
    if (got.chosen !== want.chosen) report_field("chosen_factory", want.chosen, got.chosen);
    if (got.job_c !== want.job_c) report_field("job_completion", want.job_c, got.job_c);
    if (got.set_c !== want.set_c) report_field("set_completion", want.set_c, got.set_c);
    if (got.total !== want.total) report_field("total_flowtime", want.total, got.total);
    if (got.sat !== want.sat) report_field("saturated", want.sat, got.sat);
  endfunction

  // result side: check, stall on a rotating mask, long hold on request
  initial begin : sink
    logic [15:0] ready_mask;
    int tick, hold_left, holds_seen;
    ready_mask = '1;
    tick       = 0;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_result(result_t'(out_tdata));
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (tick % 64 == 0)
        ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !stall_on || ready_mask[tick % 16];
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    request_t r;
    int n, jobs;
    clear_schedule();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_config(dir_rows[i].cfg_mu, dir_rows[i].cfg_fu);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(4'd8, 4'd4);
        1: set_config(4'd1, 4'd1);
        2: set_config(4'd8, 4'd1);
        3: set_config(4'd1, 4'd4);
        default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      idle_on  = !(ph == 1 || ph == 5);
      stall_on = (ph != 5);
      if (ph == 1) hold_reqs++;
      n = 0;
      while (n < PHASE_REQS) begin
        jobs = $urandom_range(0, 6);
        for (int j = 0; j < jobs; j++) begin
          r = '0;
          r.mode = MODE_JOB;
          for (int m = 0; m < PROC_N; m++) r.ptime[m] = rand_time();
          r.asm_time = 8'($urandom);
          send_request(r, 1'b0, NO_RES);
        end
        r = '0;
        r.mode     = MODE_ASM;
        r.asm_time = rand_time();
        r.ptime    = {$urandom, $urandom};
        send_request(r, 1'b0, NO_RES);
        n += jobs + 1;
        if ($urandom_range(0, 9) == 0) begin
          r = '0;
          r.mode     = ($urandom_range(0, 1) == 0) ? MODE_CLEAR : MODE_UNUSED;
          r.asm_time = 8'($urandom);
          r.ptime    = {$urandom, $urandom};
          send_request(r, 1'b0, NO_RES);
          n++;
        end
      end
    end

    // run maximum assembly times back to back
    set_config(4'd2, 4'd2);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    r = '0;
    r.mode = MODE_CLEAR;
    send_request(r, 1'b0, NO_RES);
    r.mode     = MODE_ASM;
    r.asm_time = 8'd255;
    for (int i = 0; i < SOAK_REQS; i++) send_request(r, 1'b0, NO_RES);
    idle_on  = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < 12; i++) begin
      r = '0;
      r.mode = (i % 4 == 3) ? MODE_ASM : MODE_JOB;
      for (int m = 0; m < PROC_N; m++) r.ptime[m] = rand_time();
      r.asm_time = rand_time();
      send_request(r, 1'b0, NO_RES);
    end

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
